// ===== rtl/core/two_joint_vertex_skinning_unit_assert.svh =====
// assertion macros for the skinning unit checker
`ifndef TWO_JOINT_VERTEX_SKINNING_UNIT_ASSERT_SVH
`define TWO_JOINT_VERTEX_SKINNING_UNIT_ASSERT_SVH

// same-cycle implication
`define TJVS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tjvs check failed");

// next-cycle implication
`define TJVS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tjvs check failed");

`endif

// ===== rtl/core/tjvs_pkg.sv =====
`default_nettype none
package tjvs_pkg;
	localparam int NUM_JOINTS = 32;
	localparam int JA_W       = $clog2(NUM_JOINTS);
	localparam int JIDX_W     = 5;
	localparam int ELEMS      = 12;
	localparam int SLOT_W     = 4;
	localparam int DW         = 32;
	localparam int FRAC_BITS  = 16;
	localparam int BLEND_BITS = 16;
	localparam int PROD_W     = 2 * DW;
	localparam int BL_W       = DW + 1 + BLEND_BITS + 2;
	localparam int SAT_W      = PROD_W + 4;
	localparam int ROUND_F    = 2 ** (FRAC_BITS - 1);
	localparam int ROUND_B    = 2 ** (BLEND_BITS - 1);

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_SKIN  = 1'b1;

	typedef logic [ELEMS-1:0][DW-1:0] mat_t;

	function automatic logic [DW-1:0] sat(input logic signed [SAT_W-1:0] v);
		logic [DW-1:0] r;
		if (&v[SAT_W-1:DW-1] || ~|v[SAT_W-1:DW-1]) begin
			r = v[DW-1:0];
		end else if (v[SAT_W-1]) begin
			r = {1'b1, {(DW-1){1'b0}}};
		end else begin
			r = {1'b0, {(DW-1){1'b1}}};
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/tjvs_mem.sv =====
`default_nettype none
// joint matrix table: one bank per element slot, one write and two read ports
module tjvs_mem (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [tjvs_pkg::JA_W-1:0] wjoint,
	input  wire logic [tjvs_pkg::SLOT_W-1:0] wslot,
	input  wire logic [tjvs_pkg::DW-1:0]   wdata,
	input  wire logic                      re,
	input  wire logic [tjvs_pkg::JA_W-1:0] ra,
	input  wire logic [tjvs_pkg::JA_W-1:0] rb,
	output tjvs_pkg::mat_t                 rd_a,
	output tjvs_pkg::mat_t                 rd_b
);
	for (genvar g = 0; g < tjvs_pkg::ELEMS; g++) begin : g_bank
		logic [tjvs_pkg::DW-1:0] mem [tjvs_pkg::NUM_JOINTS];
		always_ff @(posedge clk) begin
			if (we && wslot == tjvs_pkg::SLOT_W'(g)) begin
				mem[wjoint] <= wdata;
			end
			if (re) begin
				rd_a[g] <= mem[ra];
				rd_b[g] <= mem[rb];
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/two_joint_vertex_skinning_unit.sv =====
// channel  dir  tuser   tdata
// s_       in   func    joint, slot, matrix value, blend, pos xyz, nrm xyz
// m_       out  -       skinned pos xyz, rotated nrm xyz
// Five register stages: table read, blend multiply, blend round, row products,
// row sums with rounding and saturation. A word may enter every cycle unless a
// stall on m_ has backed up to the input. Write words leave no result.
// arst_n clears the valid bits only; the matrix table holds nothing until written.
// A stall on m_ backs up only through full stages; bubbles are squeezed out.
`default_nettype none
module two_joint_vertex_skinning_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output      logic         s_tready,
	// [4:0] joint_index, [8:5] matrix_slot, [40:9] matrix_value, [56:41] blend_frac,
	// [88:57] pos_x, [120:89] pos_y, [152:121] pos_z,
	// [184:153] nrm_x, [216:185] nrm_y, [248:217] nrm_z, [255:249] zero
	input  wire logic [255:0] s_tdata,
	// [0] func
	input  wire logic [0:0]   s_tuser,
	output      logic         m_tvalid,
	input  wire logic         m_tready,
	// [31:0] out_pos_x, [63:32] out_pos_y, [95:64] out_pos_z,
	// [127:96] out_nrm_x, [159:128] out_nrm_y, [191:160] out_nrm_z
	output      logic [191:0] m_tdata
);
	localparam int DW = tjvs_pkg::DW;
	localparam int EL = tjvs_pkg::ELEMS;

	logic [tjvs_pkg::JIDX_W-1:0] in_joint;
	logic [tjvs_pkg::SLOT_W-1:0] in_slot;
	logic [DW-1:0] in_value;
	logic [15:0] in_frac;
	logic [DW-1:0] in_pos [3];
	logic [DW-1:0] in_nrm [3];

	always_comb begin
		in_joint  = s_tdata[4:0];
		in_slot   = s_tdata[8:5];
		in_value  = s_tdata[40:9];
		in_frac   = s_tdata[56:41];
		in_pos[0] = s_tdata[88:57];
		in_pos[1] = s_tdata[120:89];
		in_pos[2] = s_tdata[152:121];
		in_nrm[0] = s_tdata[184:153];
		in_nrm[1] = s_tdata[216:185];
		in_nrm[2] = s_tdata[248:217];
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic adv1, adv2, adv3, adv4, adv5;
	logic acc, skin, wr, blend;
	logic [tjvs_pkg::JA_W-1:0] jb, jn;

	assign adv5 = !v_s5 || m_tready;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign s_tready = adv1;

	assign acc  = s_tvalid && s_tready;
	assign skin = acc && s_tuser[0] == tjvs_pkg::FUNC_SKIN;
	assign wr   = acc && s_tuser[0] == tjvs_pkg::FUNC_WRITE
		&& int'(in_joint) < tjvs_pkg::NUM_JOINTS && int'(in_slot) < EL;

	always_comb begin
		if (int'(in_joint) >= tjvs_pkg::NUM_JOINTS) begin
			jb = tjvs_pkg::JA_W'(tjvs_pkg::NUM_JOINTS - 1);
		end else begin
			jb = tjvs_pkg::JA_W'(in_joint);
		end
		blend = in_frac != '0 && int'(jb) < tjvs_pkg::NUM_JOINTS - 1;
		jn = blend ? jb + 1'b1 : jb;
	end

	tjvs_pkg::mat_t rd_a, rd_b;

	tjvs_mem u_mem (
		.clk    (clk),
		.we     (wr),
		.wjoint (tjvs_pkg::JA_W'(in_joint)),
		.wslot  (in_slot),
		.wdata  (in_value),
		.re     (adv1),
		.ra     (jb),
		.rb     (jn),
		.rd_a   (rd_a),
		.rd_b   (rd_b)
	);

	// stage 1: table read (rd_a/rd_b) plus vertex
	logic        blend_s1;
	logic [15:0] frac_s1;
	logic [DW-1:0] pos_s1 [3];
	logic [DW-1:0] nrm_s1 [3];

	always_ff @(posedge clk) begin
		if (adv1) begin
			blend_s1 <= blend;
			frac_s1  <= in_frac;
			pos_s1   <= in_pos;
			nrm_s1   <= in_nrm;
		end
	end

	// stage 2: (b - a) * frac + half
	logic signed [tjvs_pkg::BL_W-1:0] d_c [EL];
	logic signed [tjvs_pkg::BL_W-1:0] d_s2 [EL];
	logic [DW-1:0] a_s2 [EL];
	logic          blend_s2;
	logic [DW-1:0] pos_s2 [3];
	logic [DW-1:0] nrm_s2 [3];

	always_comb begin
		for (int k = 0; k < EL; k++) begin
			d_c[k] = tjvs_pkg::BL_W'($signed({rd_b[k][DW-1], rd_b[k]})
				- $signed({rd_a[k][DW-1], rd_a[k]}))
				* tjvs_pkg::BL_W'($signed({1'b0, frac_s1}))
				+ tjvs_pkg::BL_W'(tjvs_pkg::ROUND_B);
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			for (int k = 0; k < EL; k++) begin
				d_s2[k] <= d_c[k];
				a_s2[k] <= rd_a[k];
			end
			blend_s2 <= blend_s1;
			pos_s2   <= pos_s1;
			nrm_s2   <= nrm_s1;
		end
	end

	// stage 3: blended matrix
	logic [DW-1:0] m_s3 [EL];
	logic [DW-1:0] pos_s3 [3];
	logic [DW-1:0] nrm_s3 [3];

	always_ff @(posedge clk) begin
		if (adv3) begin
			for (int k = 0; k < EL; k++) begin
				if (blend_s2) begin
					m_s3[k] <= tjvs_pkg::sat(tjvs_pkg::SAT_W'($signed(a_s2[k]))
						+ tjvs_pkg::SAT_W'(d_s2[k] >>> tjvs_pkg::BLEND_BITS));
				end else begin
					m_s3[k] <= a_s2[k];
				end
			end
			pos_s3 <= pos_s2;
			nrm_s3 <= nrm_s2;
		end
	end

	// stage 4: row products
	logic signed [tjvs_pkg::PROD_W-1:0] pp_s4 [3][3];
	logic signed [tjvs_pkg::PROD_W-1:0] pn_s4 [3][3];
	logic [DW-1:0] t_s4 [3];

	always_ff @(posedge clk) begin
		if (adv4) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					pp_s4[r][c] <= $signed(m_s3[4*r+c]) * $signed(pos_s3[c]);
					pn_s4[r][c] <= $signed(m_s3[4*r+c]) * $signed(nrm_s3[c]);
				end
				t_s4[r] <= m_s3[4*r+3];
			end
		end
	end

	// stage 5: sums, rounding, translation, saturation
	logic signed [tjvs_pkg::SAT_W-1:0] sp_c [3];
	logic signed [tjvs_pkg::SAT_W-1:0] sn_c [3];
	logic [DW-1:0] op_s5 [3];
	logic [DW-1:0] on_s5 [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sp_c[r] = tjvs_pkg::SAT_W'(pp_s4[r][0]) + tjvs_pkg::SAT_W'(pp_s4[r][1])
				+ tjvs_pkg::SAT_W'(pp_s4[r][2]) + tjvs_pkg::SAT_W'(tjvs_pkg::ROUND_F);
			sn_c[r] = tjvs_pkg::SAT_W'(pn_s4[r][0]) + tjvs_pkg::SAT_W'(pn_s4[r][1])
				+ tjvs_pkg::SAT_W'(pn_s4[r][2]) + tjvs_pkg::SAT_W'(tjvs_pkg::ROUND_F);
		end
	end

	always_ff @(posedge clk) begin
		if (adv5) begin
			for (int r = 0; r < 3; r++) begin
				op_s5[r] <= tjvs_pkg::sat((sp_c[r] >>> tjvs_pkg::FRAC_BITS)
					+ tjvs_pkg::SAT_W'($signed(t_s4[r])));
				on_s5[r] <= tjvs_pkg::sat(sn_c[r] >>> tjvs_pkg::FRAC_BITS);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= skin;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
		end
	end

	assign m_tvalid = v_s5;
	assign m_tdata  = {on_s5[2], on_s5[1], on_s5[0], op_s5[2], op_s5[1], op_s5[0]};
endmodule
`default_nettype wire

// ===== rtl/core/tjvs_chk.sv =====
`default_nettype none
`include "two_joint_vertex_skinning_unit_assert.svh"
module tjvs_chk (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [191:0] m_tdata
);
	// a held result word does not change
	`TJVS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// input only backs up when the output is stalled
	`TJVS_ASSERT_NOW(a_bp_cause, !s_tready, m_tvalid && !m_tready)
	// an empty output stage never blocks input
	`TJVS_ASSERT_NOW(a_empty_ready, !m_tvalid, s_tready)
endmodule

bind two_joint_vertex_skinning_unit tjvs_chk u_tjvs_chk (.*);
`default_nettype wire

// ===== tb/two_joint_vertex_skinning_unit_test.sv =====
`default_nettype none
class skin_scoreboard;
	logic signed [31:0] mtab [0:383];
	logic [191:0] pending [$];
	int errors;

	function new();
		errors = 0;
		for (int i = 0; i < 384; i++) begin
			mtab[i] = 0;
		end
	endfunction

	static function longint fshift(longint v, int s);
		return v >>> s;
	endfunction

	static function longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	static function longint dot3(longint m0, longint m1, longint m2,
		longint v0, longint v1, longint v2);
		longint p[3];
		longint m[3];
		longint v[3];
		longint hi;
		longint lo;
		m[0] = m0; m[1] = m1; m[2] = m2;
		v[0] = v0; v[1] = v1; v[2] = v2;
		hi = 0;
		lo = 64'sd32768;
		for (int c = 0; c < 3; c++) begin
			p[c] = m[c] * v[c];
			hi += fshift(p[c], 16);
			lo += p[c] & 64'hFFFF;
		end
		return hi + fshift(lo, 16);
	endfunction

	function void note_input(logic func, logic [255:0] d);
		int j;
		int slot;
		longint m[12];
		longint a;
		longint b;
		longint dd;
		longint frac;
		longint pv[3];
		longint nv[3];
		logic [191:0] res;
		j = int'(d[4:0]);
		if (func == tjvs_pkg::FUNC_WRITE) begin
			slot = int'(d[8:5]);
			if (slot < 12) begin
				mtab[j * 12 + slot] = d[40:9];
			end
			return;
		end
		frac = longint'(d[56:41]);
		for (int k = 0; k < 12; k++) begin
			a = longint'(mtab[j * 12 + k]);
			if (frac != 0 && j + 1 < 32) begin
				b = longint'(mtab[(j + 1) * 12 + k]);
				dd = (b - a) * frac + 64'sd32768;
				a = sat32(a + fshift(dd, 16));
			end
			m[k] = a;
		end
		for (int k = 0; k < 3; k++) begin
			pv[k] = longint'($signed(d[57 + 32 * k +: 32]));
			nv[k] = longint'($signed(d[153 + 32 * k +: 32]));
		end
		for (int r = 0; r < 3; r++) begin
			res[32 * r +: 32] = 32'(sat32(dot3(m[4*r], m[4*r+1], m[4*r+2],
				pv[0], pv[1], pv[2]) + m[4*r+3]));
			res[96 + 32 * r +: 32] = 32'(sat32(dot3(m[4*r], m[4*r+1], m[4*r+2],
				nv[0], nv[1], nv[2])));
		end
		pending.push_back(res);
	endfunction

	function void check_result(logic [191:0] got);
		logic [191:0] want;
		if (pending.size() == 0) begin
			$display("%0t unexpected result %h", $time, got);
			errors++;
			return;
		end
		want = pending.pop_front();
		for (int f = 0; f < 6; f++)
			if (got[32 * f +: 32] !== want[32 * f +: 32]) begin
				$display("%0t field %0d expected %h actual %h", $time, f,
					want[32 * f +: 32], got[32 * f +: 32]);
				errors++;
			end
	endfunction
endclass

module two_joint_vertex_skinning_unit_test;
	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [255:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [191:0] m_tdata;
	int src_idle = 0;
	int snk_idle = 0;
	int quiet = 0;
	skin_scoreboard sb = new();

	two_joint_vertex_skinning_unit dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) sb.check_result(m_tdata);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
		else quiet++;
		if (quiet > 5000) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(negedge clk)
		m_tready <= arst_n && ($urandom_range(99) >= snk_idle);

	function automatic logic [31:0] rnd_val();
		case ($urandom_range(5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return $urandom_range(131072) - 65536;
			default: return $urandom;
		endcase
	endfunction

	task automatic send(logic func, logic [255:0] d);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= func;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_input(func, d);
		@(negedge clk);
	endtask

	task automatic write_elem(int j, int slot, logic [31:0] v);
		logic [255:0] d;
		d = '0;
		d[4:0] = 5'(j);
		d[8:5] = 4'(slot);
		d[40:9] = v;
		send(tjvs_pkg::FUNC_WRITE, d);
	endtask

	task automatic skin(int j, logic [15:0] fr, logic [191:0] vec);
		logic [255:0] d;
		d = '0;
		d[4:0] = 5'(j);
		d[8:5] = 4'($urandom);
		d[40:9] = $urandom;
		d[56:41] = fr;
		d[248:57] = vec;
		send(tjvs_pkg::FUNC_SKIN, d);
	endtask

	function automatic logic [191:0] rnd_vec();
		logic [191:0] v;
		for (int k = 0; k < 6; k++) v[32 * k +: 32] = rnd_val();
		return v;
	endfunction

	initial begin
		int n;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		for (int j = 0; j < 32; j++)
			for (int s = 0; s < 12; s++)
				write_elem(j, s, (s % 5 == 0) ? 32'h00010000 : rnd_val());
		write_elem(3, 12, 32'h12345678);
		write_elem(3, 15, 32'h12345678);
		skin(0, 0, {6{32'h00010000}});
		skin(0, 16'hFFFF, {6{32'h7FFFFFFF}});
		skin(31, 16'h8000, {6{32'h80000000}});
		skin(31, 0, rnd_vec());
		skin(5, 1, rnd_vec());
		skin(30, 16'hFFFF, rnd_vec());
		for (int ph = 0; ph < 3; ph++) begin
			src_idle = (ph == 0) ? 9 : (ph == 1) ? 62 : 0;
			snk_idle = (ph == 0) ? 62 : (ph == 1) ? 9 : 0;
			for (n = 0; n < 240; n++) begin
				if ($urandom_range(3) == 0)
					write_elem($urandom_range(31), $urandom_range(15), rnd_val());
				else
					skin($urandom_range(31),
						($urandom_range(3) == 0) ? 16'd0 : 16'($urandom), rnd_vec());
			end
		end
		s_tvalid <= 0;
		n = 0;
		while (sb.pending.size() != 0 && n < 20000) begin
			@(posedge clk);
			n++;
		end
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/tjvs_pkg.sv
rtl/core/tjvs_mem.sv
rtl/core/two_joint_vertex_skinning_unit.sv
rtl/core/tjvs_chk.sv
tb/two_joint_vertex_skinning_unit_test.sv
